// File: rtl/link_packet_responder_macros.svh
// Assertion macros used by the checker file.
`ifndef LINK_PACKET_RESPONDER_MACROS_SVH
`define LINK_PACKET_RESPONDER_MACROS_SVH

// Implication in the same cycle.
`define LPR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the next cycle.
`define LPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/lpr_pkg.sv
package lpr_pkg;

  localparam int HDR_LEN         = 12;
  localparam int MAX_PAYLOAD_DEF = 1472;
  localparam int JOB_DEPTH       = 2;
  localparam logic [10:0] COUNT_MAX = 11'h7FF;

  localparam logic [1:0] CFG_OWN    = 2'd0;
  localparam logic [1:0] CFG_PEER   = 2'd1;
  localparam logic [1:0] CFG_MAXLEN = 2'd2;

  localparam logic [3:0] ST_STREAM  = 4'd0;
  localparam logic [3:0] ST_ADDR    = 4'd1;
  localparam logic [3:0] ST_TIME    = 4'd2;
  localparam logic [3:0] ST_UNKNOWN = 4'd3;
  localparam logic [3:0] ST_ACK     = 4'd4;
  localparam logic [3:0] ST_NOTMINE = 4'd5;
  localparam logic [3:0] ST_BAD     = 4'd6;
  localparam logic [3:0] ST_MALFORM = 4'd7;
  localparam logic [3:0] ST_UNHAND  = 4'd8;

  localparam logic [6:0] SVC_ADDR    = 7'd1;
  localparam logic [6:0] SVC_TIME    = 7'd2;
  localparam logic [6:0] SVC_STREAM  = 7'd4;
  localparam logic [6:0] SVC_UNKNOWN = 7'd8;

  typedef enum logic [1:0] {
    RESP_NONE,
    RESP_ADDR,
    RESP_TIME,
    RESP_UNK
  } resp_t;

  typedef struct packed {
    logic        ack;
    logic [7:0]  misc;
    logic [7:0]  svc;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [7:0]  unk;
    logic [7:0]  req;
    logic [15:0] seq_rx;
    resp_t       resp;
    logic [15:0] tx_seq;
    logic [7:0]  own;
    logic [7:0]  peer;
    logic [31:0] secs;
    logic [3:0]  status;
    logic [10:0] plen;
    logic        hs;
  } job_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        packet_end;
    logic [3:0]  status;
    logic [10:0] payload_length;
    logic        handshake_done;
    logic        last;
  } word_t;

  function automatic logic [15:0] add_fold(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? (s[15:0] + 16'd1) : s[15:0];
  endfunction

  function automatic logic [15:0] sum_fold(logic [19:0] s);
    logic [16:0] t;
    t = {1'b0, s[15:0]} + {13'd0, s[19:16]};
    return t[15:0] + {15'd0, t[16]};
  endfunction

endpackage

// File: rtl/lpr_front.sv
module lpr_front #(
  parameter int MAX_PAYLOAD = lpr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_take,
  input  logic [7:0]        rx_byte,
  input  logic              rx_end,
  input  logic [31:0]       time_seconds,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [10:0]       cfg_data,
  output logic              job_push,
  output lpr_pkg::job_t     job
);

  localparam logic [10:0] LEN_CAP = 11'(lpr_pkg::HDR_LEN + MAX_PAYLOAD);
  localparam logic [10:0] HDR11   = 11'(lpr_pkg::HDR_LEN);

  logic [7:0]  own_address;
  logic [7:0]  peer_address;
  logic [10:0] max_packet_length;
  logic [7:0]  header [lpr_pkg::HDR_LEN];
  logic [7:0]  first_payload;
  logic [15:0] sum_accumulator;
  logic [7:0]  pending_high;
  logic [10:0] byte_count;
  logic [15:0] tx_sequence;
  logic        handshake_flag;

  logic [7:0]  pending_next;
  logic [15:0] sum_next;
  logic [10:0] count_next;
  logic [15:0] acc;
  logic [7:0]  fp;
  logic [15:0] len;
  logic [10:0] limit;
  logic        bad;
  logic [15:0] seq_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address       <= 8'hFE;
      peer_address      <= 8'h01;
      max_packet_length <= 11'd1488;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lpr_pkg::CFG_OWN:    own_address       <= cfg_data[7:0];
        lpr_pkg::CFG_PEER:   peer_address      <= cfg_data[7:0];
        lpr_pkg::CFG_MAXLEN: max_packet_length <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && byte_count < HDR11) begin
      header[byte_count[3:0]] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_payload   <= '0;
      sum_accumulator <= '0;
      pending_high    <= '0;
      byte_count      <= '0;
      tx_sequence     <= '0;
      handshake_flag  <= 1'b0;
    end else if (in_take) begin
      if (byte_count == HDR11) begin
        first_payload <= rx_byte;
      end
      if (rx_end) begin
        sum_accumulator <= '0;
        pending_high    <= '0;
        byte_count      <= '0;
        tx_sequence     <= tx_sequence + seq_step;
        handshake_flag  <= job.hs;
      end else begin
        sum_accumulator <= sum_next;
        pending_high    <= pending_next;
        byte_count      <= count_next;
      end
    end
  end

  always_comb begin
    pending_next = byte_count[0] ? pending_high : rx_byte;
    sum_next     = byte_count[0] ? lpr_pkg::add_fold(sum_accumulator, {pending_high, rx_byte})
                                 : sum_accumulator;
    count_next   = (byte_count == lpr_pkg::COUNT_MAX) ? byte_count : byte_count + 11'd1;
    acc          = count_next[0] ? lpr_pkg::add_fold(sum_next, {pending_next, 8'h00})
                                 : sum_next;
    fp           = (byte_count == HDR11) ? rx_byte : first_payload;
    len          = {header[6], header[7]};
    limit        = (max_packet_length > LEN_CAP) ? LEN_CAP : max_packet_length;
    bad          = (count_next < HDR11) || (len < 16'(lpr_pkg::HDR_LEN))
                || (len > {5'd0, limit}) || (len != {5'd0, count_next})
                || (acc != 16'hFFFF);
  end

  always_comb begin
    job        = '0;
    job.misc   = header[0];
    job.svc    = header[1];
    job.src    = header[2];
    job.dst    = header[3];
    job.unk    = header[4];
    job.req    = header[5];
    job.seq_rx = {header[8], header[9]};
    job.tx_seq = tx_sequence;
    job.own    = own_address;
    job.peer   = peer_address;
    job.secs   = time_seconds;
    job.resp   = lpr_pkg::RESP_NONE;
    job.status = lpr_pkg::ST_UNHAND;
    priority if (bad) begin
      job.status = lpr_pkg::ST_BAD;
    end else if (header[3] != own_address && header[3] != 8'hFF) begin
      job.status = lpr_pkg::ST_NOTMINE;
    end else if (header[1][7]) begin
      job.status = lpr_pkg::ST_ACK;
    end else begin
      job.ack = header[5][0];
      unique case (header[1][6:0])
        lpr_pkg::SVC_ADDR: begin
          if (len < 16'd77 || fp != 8'h00) begin
            job.status = lpr_pkg::ST_MALFORM;
          end else begin
            job.status = lpr_pkg::ST_ADDR;
            job.resp   = lpr_pkg::RESP_ADDR;
          end
        end
        lpr_pkg::SVC_TIME: begin
          if (len < 16'd13 || fp != 8'h00) begin
            job.status = lpr_pkg::ST_MALFORM;
          end else begin
            job.status = lpr_pkg::ST_TIME;
            job.resp   = lpr_pkg::RESP_TIME;
          end
        end
        lpr_pkg::SVC_UNKNOWN: begin
          if (len != 16'd13 || fp != 8'h01) begin
            job.status = lpr_pkg::ST_MALFORM;
          end else begin
            job.status = lpr_pkg::ST_UNKNOWN;
            job.resp   = lpr_pkg::RESP_UNK;
          end
        end
        lpr_pkg::SVC_STREAM: begin
          job.status = lpr_pkg::ST_STREAM;
          job.plen   = 11'(len - 16'(lpr_pkg::HDR_LEN));
        end
        default: job.status = lpr_pkg::ST_UNHAND;
      endcase
    end
    job.hs = handshake_flag | (job.resp == lpr_pkg::RESP_TIME);
  end

  always_comb begin
    unique case (job.resp)
      lpr_pkg::RESP_ADDR: seq_step = 16'd2;
      lpr_pkg::RESP_TIME: seq_step = 16'd1;
      lpr_pkg::RESP_UNK:  seq_step = 16'd1;
      default:            seq_step = 16'd0;
    endcase
  end

  assign job_push = in_take && rx_end;

endmodule

// File: rtl/lpr_job_fifo.sv
module lpr_job_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lpr_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output lpr_pkg::job_t rdata,
  output logic          empty
);

  localparam int PW = (lpr_pkg::JOB_DEPTH > 1) ? $clog2(lpr_pkg::JOB_DEPTH) : 1;
  localparam int CW = $clog2(lpr_pkg::JOB_DEPTH + 1);

  lpr_pkg::job_t mem [lpr_pkg::JOB_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(lpr_pkg::JOB_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(lpr_pkg::JOB_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(lpr_pkg::JOB_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

// File: rtl/lpr_back.sv
module lpr_back (
  input  logic           clk,
  input  logic           rst,
  input  lpr_pkg::job_t  job,
  input  logic           job_valid,
  output logic           job_pop,
  output logic           out_valid,
  input  logic           out_pop,
  output lpr_pkg::word_t out_word
);

  typedef enum logic [2:0] {
    PH_ACK  = 3'b001,
    PH_RESP = 3'b010,
    PH_STAT = 3'b100
  } phase_t;

  phase_t         phase;
  phase_t         eff;
  logic [4:0]     idx;
  logic           second;
  logic           advance;
  logic           out_ready;
  logic [4:0]     rlen;
  logic [15:0]    rseq;
  logic [15:0]    ack_ck;
  logic [15:0]    resp_ck;
  logic [19:0]    ack_sum;
  logic [19:0]    resp_sum;
  logic [15:0]    pay_sum;
  logic [7:0]     ack_b;
  logic [7:0]     resp_b;
  lpr_pkg::word_t word;

  assign out_ready = !out_valid || out_pop;
  assign advance   = job_valid && out_ready;
  assign job_pop   = advance && (eff == PH_STAT);

  always_comb begin
    priority if (phase == PH_ACK && !job.ack) begin
      eff = (job.resp == lpr_pkg::RESP_NONE) ? PH_STAT : PH_RESP;
    end else if (phase == PH_RESP && job.resp == lpr_pkg::RESP_NONE) begin
      eff = PH_STAT;
    end else begin
      eff = phase;
    end
  end

  always_comb begin
    unique case (job.resp)
      lpr_pkg::RESP_TIME: rlen = 5'd29;
      lpr_pkg::RESP_UNK:  rlen = 5'd14;
      default:            rlen = 5'd13;
    endcase
    rseq    = job.tx_seq + {15'd0, second};
    ack_sum = {4'd0, job.misc, job.svc | 8'h80} + {4'd0, job.dst, job.src}
            + {4'd0, job.unk, job.req & 8'hFE} + 20'd12 + {4'd0, job.seq_rx};
    unique case (job.resp)
      lpr_pkg::RESP_TIME: pay_sum = lpr_pkg::add_fold(
                            lpr_pkg::add_fold({8'h80, job.secs[31:24]}, job.secs[23:8]),
                            {job.secs[7:0], 8'h00});
      lpr_pkg::RESP_UNK:  pay_sum = 16'h8103;
      default:            pay_sum = 16'h8000;
    endcase
    resp_sum = {12'd0, job.svc} + {4'd0, job.own, job.peer} + {15'd0, rlen}
             + {4'd0, rseq} + {4'd0, pay_sum};
    ack_ck   = ~lpr_pkg::sum_fold(ack_sum);
    resp_ck  = ~lpr_pkg::sum_fold(resp_sum);
  end

  always_comb begin
    unique case (idx)
      5'd0:    ack_b = job.misc;
      5'd1:    ack_b = job.svc | 8'h80;
      5'd2:    ack_b = job.dst;
      5'd3:    ack_b = job.src;
      5'd4:    ack_b = job.unk;
      5'd5:    ack_b = job.req & 8'hFE;
      5'd7:    ack_b = 8'(lpr_pkg::HDR_LEN);
      5'd8:    ack_b = job.seq_rx[15:8];
      5'd9:    ack_b = job.seq_rx[7:0];
      5'd10:   ack_b = ack_ck[15:8];
      5'd11:   ack_b = ack_ck[7:0];
      default: ack_b = 8'h00;
    endcase
  end

  always_comb begin
    unique case (idx)
      5'd1:    resp_b = job.svc;
      5'd2:    resp_b = job.own;
      5'd3:    resp_b = job.peer;
      5'd7:    resp_b = {3'd0, rlen};
      5'd8:    resp_b = rseq[15:8];
      5'd9:    resp_b = rseq[7:0];
      5'd10:   resp_b = resp_ck[15:8];
      5'd11:   resp_b = resp_ck[7:0];
      5'd12:   resp_b = (job.resp == lpr_pkg::RESP_UNK) ? 8'h81 : 8'h80;
      5'd13:   resp_b = (job.resp == lpr_pkg::RESP_UNK) ? 8'h03
                      : (job.resp == lpr_pkg::RESP_TIME) ? job.secs[31:24] : 8'h00;
      5'd14:   resp_b = (job.resp == lpr_pkg::RESP_TIME) ? job.secs[23:16] : 8'h00;
      5'd15:   resp_b = (job.resp == lpr_pkg::RESP_TIME) ? job.secs[15:8] : 8'h00;
      5'd16:   resp_b = (job.resp == lpr_pkg::RESP_TIME) ? job.secs[7:0] : 8'h00;
      default: resp_b = 8'h00;
    endcase
  end

  always_comb begin
    word                = '0;
    word.handshake_done = job.hs;
    unique case (eff)
      PH_ACK: begin
        word.tx_byte    = ack_b;
        word.packet_end = (idx == 5'd11);
      end
      PH_RESP: begin
        word.tx_byte    = resp_b;
        word.packet_end = (idx == rlen - 5'd1);
      end
      default: begin
        word.kind           = 1'b1;
        word.status         = job.status;
        word.payload_length = job.plen;
        word.last           = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_ACK;
      idx    <= '0;
      second <= 1'b0;
    end else if (advance) begin
      unique case (eff)
        PH_ACK: begin
          if (idx == 5'd11) begin
            phase <= (job.resp == lpr_pkg::RESP_NONE) ? PH_STAT : PH_RESP;
            idx   <= '0;
          end else begin
            idx <= idx + 5'd1;
          end
        end
        PH_RESP: begin
          if (idx == rlen - 5'd1) begin
            idx <= '0;
            if (job.resp == lpr_pkg::RESP_ADDR && !second) begin
              second <= 1'b1;
              phase  <= PH_RESP;
            end else begin
              phase <= PH_STAT;
            end
          end else begin
            idx <= idx + 5'd1;
          end
        end
        default: begin
          phase  <= PH_ACK;
          idx    <= '0;
          second <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= word;
    end
  end

endmodule

// File: rtl/link_packet_responder.sv
// Link packet responder. Received packet bytes are pushed one word per cycle;
// the receiver takes a byte every cycle as long as full is low, and full is
// high only while the two-entry queue of finished packets awaiting a response
// is full. Each finished packet is answered by the transmit sequencer at
// one result word per cycle while pop keeps up: a 12-word acknowledgement when
// requested, then 26 words for an address request, 29 for a time request or
// 14 for an unknown-service request, and always one status word last. The
// configuration port is always ready and should be written only while no
// packet is in flight.
module link_packet_responder #(
  parameter int MAX_PAYLOAD = lpr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  input  logic        rx_end,
  input  logic [31:0] time_seconds,
  output logic        empty,
  input  logic        pop,
  output logic        kind,
  output logic [7:0]  tx_byte,
  output logic        packet_end,
  output logic [3:0]  status,
  output logic [10:0] payload_length,
  output logic        handshake_done,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  lpr_pkg::job_t  job_in;
  lpr_pkg::job_t  job_head;
  lpr_pkg::word_t out_word;
  logic           job_push;
  logic           job_full;
  logic           job_empty;
  logic           job_pop;
  logic           out_valid;

  assign cfg_ready = 1'b1;
  assign full      = job_full;

  lpr_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_take      (push && !job_full),
    .rx_byte      (rx_byte),
    .rx_end       (rx_end),
    .time_seconds (time_seconds),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .job_push     (job_push),
    .job          (job_in)
  );

  lpr_job_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_head),
    .empty (job_empty)
  );

  lpr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job_head),
    .job_valid (!job_empty),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_pop   (pop),
    .out_word  (out_word)
  );

  assign empty          = !out_valid;
  assign kind           = out_word.kind;
  assign tx_byte        = out_word.tx_byte;
  assign packet_end     = out_word.packet_end;
  assign status         = out_word.status;
  assign payload_length = out_word.payload_length;
  assign handshake_done = out_word.handshake_done;
  assign last           = out_word.last;

endmodule

// File: rtl/lpr_checker.sv
`include "link_packet_responder_macros.svh"

module lpr_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic        kind,
  input logic [7:0]  tx_byte,
  input logic        packet_end,
  input logic [3:0]  status,
  input logic [10:0] payload_length,
  input logic        last
);

  `LPR_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(tx_byte) && $stable(last))
  `LPR_ASSERT_NOW(a_byte_word, !empty && !kind, !last && status == lpr_pkg::ST_STREAM && payload_length == 11'd0)
  `LPR_ASSERT_NOW(a_status_word, !empty && kind, last && tx_byte == 8'd0 && !packet_end)
  `LPR_ASSERT_NOW(a_plen_stream, !empty && kind && status != lpr_pkg::ST_STREAM, payload_length == 11'd0)

endmodule

bind link_packet_responder lpr_checker u_checker (.*);
